@@ hdl/command_packet_validator_core_defines.svh @@
// Assertion helpers used by the top-level core.
`ifndef COMMAND_PACKET_VALIDATOR_CORE_DEFINES_SVH
`define COMMAND_PACKET_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define CPV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpv assertion failed");

// next-cycle implication, held off during reset
`define CPV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpv assertion failed");

`endif

@@ hdl/cpv_pkg.sv @@
package cpv_pkg;

  // status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_SHORT     = 3'd1;
  localparam logic [2:0] STAT_MISMATCH  = 3'd2;
  localparam logic [2:0] STAT_UNKNOWN   = 3'd3;
  localparam logic [2:0] STAT_NONPRINT  = 3'd4;
  localparam logic [2:0] STAT_TOO_LONG  = 3'd5;
  localparam logic [2:0] STAT_BAD_MODE  = 3'd6;

  // packet commands
  localparam logic [7:0] CMD_RENAME = 8'h01;
  localparam logic [7:0] CMD_MODE   = 8'h02;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  localparam logic [8:0] POS_MAX = 9'd511;

  // read_index is 4 bits, so only this many label entries can ever be seen
  localparam int LBL_VIS = 16;

  // request passed from front to back
  typedef struct packed {
    logic                      is_read;
    logic [3:0]                idx;
    logic [2:0]                status;
    logic                      commit;
    logic                      set_diag;
    logic                      diag_val;
    logic [3:0]                len_lo;
    logic                      len_big;   // length is 16 or more
    logic [LBL_VIS-1:0][7:0]   label;
  } req_t;

  function automatic logic [7:0] safe_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0: c = "s";
      2'd1: c = "a";
      2'd2: c = "f";
      2'd3: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] diag_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0: c = "d";
      2'd1: c = "i";
      2'd2: c = "a";
      2'd3: c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] reset_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = "s";
      4'd1: c = "e";
      4'd2: c = "n";
      4'd3: c = "s";
      4'd4: c = "o";
      4'd5: c = "r";
      4'd6: c = "-";
      4'd7: c = "a";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/cpv_if.sv @@
interface cpv_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       last;
  logic [3:0] read_index;

  modport source (output valid, output cmd, output data_byte, output last,
                  output read_index, input ready);
  modport sink   (input valid, input cmd, input data_byte, input last,
                  input read_index, output ready);
endinterface

interface cpv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       diag_mode;
  logic [3:0] label_length;
  logic [7:0] label_char;

  modport source (output valid, output status, output diag_mode,
                  output label_length, output label_char, input ready);
  modport sink   (input valid, input status, input diag_mode,
                  input label_length, input label_char, output ready);
endinterface

@@ hdl/command_packet_validator_core.sv @@
// Command packet validator. Requests arrive one per cycle on in_chan: a
// packet byte (cmd 0, last marks the end) or a label read (cmd 1). Byte 0
// of a packet is the declared payload length, byte 1 the command, the rest
// payload. Non-final bytes give no result; a final byte gives one status
// (short, length mismatch, unknown command, non-printable, label too long,
// invalid mode, checked in that order), and a read gives one label byte.
// Rate: one request per cycle while in_chan.ready is high. A request that
// makes a result is written into a two-entry queue when it is accepted, and
// the back stage moves it into the output register once that register is
// empty or being taken; out_chan.valid rises with that move. in_chan.ready
// drops only when the queue holds two requests, which needs out_chan to
// stall with three results waiting.
// Non-final packet bytes never enter the queue.
// Label length and characters reflect every packet committed before; only
// the first 16 label characters can be read back.
`include "command_packet_validator_core_defines.svh"

module command_packet_validator_core #(
  parameter int LABEL_DEPTH = 16   // 2..64
) (
  input  logic       clk,
  input  logic       rst_n,
  cpv_in_if.sink     in_chan,
  cpv_out_if.source  out_chan
);
  import cpv_pkg::*;

  // front -> queue
  logic  push;
  req_t  push_req;
  // queue -> back
  req_t  head;
  logic  pop;
  logic  q_full;
  logic  q_empty;
  // failing status on the output
  logic  fail_out;

  // front: tracks packet position, length, command, printable and mode
  // match state, and classifies the packet at its last byte
  cpv_front #(
    .LABEL_DEPTH (LABEL_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_req (push_req)
  );

  // decouples front from output stalls
  cpv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: owns label, length and diag flag; commits and serves reads in order
  cpv_back #(
    .LABEL_DEPTH (LABEL_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_chan (out_chan)
  );

  assign fail_out = out_chan.valid && (out_chan.status != STAT_OK);

  `CPV_ASSERT_IMP(a_q_sane, clk, rst_n, 1'b1, !(q_full && q_empty))
  `CPV_ASSERT_NXT(a_pop_out, clk, rst_n, pop, out_chan.valid)
  `CPV_ASSERT_IMP(a_fail_no_char, clk, rst_n, fail_out, out_chan.label_char == 8'h00)

endmodule

@@ hdl/cpv_front.sv @@
module cpv_front #(
  parameter int LABEL_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  cpv_in_if.sink         in_chan,
  input  logic           q_full,
  output logic           push,
  output cpv_pkg::req_t  push_req
);
  import cpv_pkg::*;

  localparam int LS = (LABEL_DEPTH < LBL_VIS) ? LABEL_DEPTH : LBL_VIS;

  logic [8:0]         pos_r, pos_nxt;
  logic [7:0]         decl_r, decl_nxt;
  logic [7:0]         cmd_r, cmd_nxt;
  logic               print_r, print_nxt;
  logic [1:0]         match_r, match_nxt;
  logic [LS-1:0][7:0] stage_r, stage_nxt;

  logic               acc;
  logic               payload;
  logic [8:0]         p;
  logic [8:0]         count;
  logic [8:0]         plen;
  logic [LBL_VIS-1:0][7:0] lbl_eff;
  logic [LBL_VIS-1:0] hit;

  assign in_chan.ready = !q_full;
  assign acc     = in_chan.valid && in_chan.ready;
  assign payload = (pos_r >= 9'd2);
  assign p       = pos_r - 9'd2;
  assign count   = (pos_r == POS_MAX) ? POS_MAX : pos_r + 9'd1;
  assign plen    = count - 9'd2;

  // staged label with the current byte merged in
  for (genvar i = 0; i < LBL_VIS; i++) begin : g_lbl
    assign hit[i] = payload && (p == 9'(i));
    if (i < LS) begin : g_kept
      assign lbl_eff[i] = hit[i] ? in_chan.data_byte : stage_r[i];
    end else begin : g_drop
      assign lbl_eff[i] = 8'h00;
    end
  end

  always_comb begin
    logic [7:0] b;
    b         = in_chan.data_byte;
    decl_nxt  = (pos_r == 9'd0) ? b : decl_r;
    cmd_nxt   = (pos_r == 9'd1) ? b : cmd_r;
    print_nxt = print_r;
    match_nxt = match_r;
    stage_nxt = stage_r;
    if (payload) begin
      if (b < PRINT_LO || b > PRINT_HI) print_nxt = 1'b0;
      if (p < 9'd4) begin
        if (b != safe_char(p[1:0])) match_nxt[0] = 1'b0;
        if (b != diag_char(p[1:0])) match_nxt[1] = 1'b0;
      end else begin
        match_nxt = 2'b00;
      end
      for (int i = 0; i < LS; i++) begin
        if (hit[i]) stage_nxt[i] = b;
      end
    end
    pos_nxt = count;

    push_req          = '0;
    push_req.idx      = in_chan.read_index;
    push_req.label    = lbl_eff;
    push_req.len_lo   = plen[3:0];
    push_req.len_big  = |plen[8:4];
    if (in_chan.cmd) begin
      push_req.is_read = 1'b1;
    end else if (count < 9'd2) begin
      push_req.status = STAT_SHORT;
    end else if (plen != {1'b0, decl_nxt}) begin
      push_req.status = STAT_MISMATCH;
    end else if (cmd_nxt != CMD_RENAME && cmd_nxt != CMD_MODE) begin
      push_req.status = STAT_UNKNOWN;
    end else if (!print_nxt) begin
      push_req.status = STAT_NONPRINT;
    end else if (cmd_nxt == CMD_RENAME) begin
      if (plen >= 9'(LABEL_DEPTH)) begin
        push_req.status = STAT_TOO_LONG;
      end else begin
        push_req.status = STAT_OK;
        push_req.commit = 1'b1;
      end
    end else if (plen == 9'd4 && match_nxt[0]) begin
      push_req.status   = STAT_OK;
      push_req.set_diag = 1'b1;
      push_req.diag_val = 1'b0;
    end else if (plen == 9'd4 && match_nxt[1]) begin
      push_req.status   = STAT_OK;
      push_req.set_diag = 1'b1;
      push_req.diag_val = 1'b1;
    end else begin
      push_req.status = STAT_BAD_MODE;
    end
  end

  assign push = acc && (in_chan.cmd || in_chan.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      decl_r  <= '0;
      cmd_r   <= '0;
      print_r <= 1'b1;
      match_r <= 2'b11;
    end else if (acc && !in_chan.cmd) begin
      if (in_chan.last) begin
        pos_r   <= '0;
        decl_r  <= '0;
        cmd_r   <= '0;
        print_r <= 1'b1;
        match_r <= 2'b11;
      end else begin
        pos_r   <= pos_nxt;
        decl_r  <= decl_nxt;
        cmd_r   <= cmd_nxt;
        print_r <= print_nxt;
        match_r <= match_nxt;
      end
    end
  end

  // only label bytes below the committed length are ever read back, so no clear
  always_ff @(posedge clk) begin
    if (acc && !in_chan.cmd) stage_r <= stage_nxt;
  end

endmodule

@@ hdl/cpv_queue.sv @@
module cpv_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cpv_pkg::req_t  push_req,
  input  logic           pop,
  output cpv_pkg::req_t  head,
  output logic           full,
  output logic           empty
);
  import cpv_pkg::*;

  req_t       ent_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_req;
  end

endmodule

@@ hdl/cpv_back.sv @@
module cpv_back #(
  parameter int LABEL_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cpv_pkg::req_t  head,
  input  logic           q_empty,
  output logic           pop,
  cpv_out_if.source      out_chan
);
  import cpv_pkg::*;

  localparam int RST_LEN = (LABEL_DEPTH - 1 < 8) ? LABEL_DEPTH - 1 : 8;

  logic [LBL_VIS-1:0][7:0] label_r, label_nxt;
  logic [3:0]              len_lo_r, len_lo_nxt;
  logic                    len_big_r, len_big_nxt;
  logic                    diag_r, diag_nxt;

  logic                    out_valid_r;
  logic [2:0]              status_r, status_nxt;
  logic                    odiag_r;
  logic [3:0]              olen_r;
  logic [7:0]              char_r, char_nxt;

  assign pop = !q_empty && (!out_valid_r || out_chan.ready);

  always_comb begin
    label_nxt   = label_r;
    len_lo_nxt  = len_lo_r;
    len_big_nxt = len_big_r;
    diag_nxt    = diag_r;
    status_nxt  = STAT_OK;
    char_nxt    = 8'h00;
    if (head.is_read) begin
      if (len_big_r || head.idx < len_lo_r) char_nxt = label_r[head.idx];
    end else begin
      status_nxt = head.status;
      if (head.commit) begin
        label_nxt   = head.label;
        len_lo_nxt  = head.len_lo;
        len_big_nxt = head.len_big;
      end
      if (head.set_diag) diag_nxt = head.diag_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LBL_VIS; i++) begin
        label_r[i] <= (i < RST_LEN) ? reset_char(4'(i)) : 8'h00;
      end
      len_lo_r    <= 4'(RST_LEN);
      len_big_r   <= 1'b0;
      diag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        label_r   <= label_nxt;
        len_lo_r  <= len_lo_nxt;
        len_big_r <= len_big_nxt;
        diag_r    <= diag_nxt;
      end
      if (pop)                 out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= status_nxt;
      odiag_r  <= diag_nxt;
      olen_r   <= len_lo_nxt;
      char_r   <= char_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.diag_mode    = odiag_r;
  assign out_chan.label_length = olen_r;
  assign out_chan.label_char   = char_r;

endmodule
